FILE: design/mmd_pkg.sv
// ---------------------------------------------------------------------------
// mmd_pkg
// Shared types, constants and pixel format helpers of the mip level
// box downsampler.
// ---------------------------------------------------------------------------
package mmd_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int IDX_W      = $clog2(LINE_DEPTH);
  localparam int WIDTH_W    = 13;
  localparam int CNT_W      = ((COL_W > WIDTH_W) ? COL_W : WIDTH_W) + 1;
  localparam int PIXEL_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = WIDTH_W;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(256);

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH    = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    FMT_A8L8     = 2'd0,
    FMT_A1R5G5B5 = 2'd1,
    FMT_R5G6B5   = 2'd2,
    FMT_A8R8G8B8 = 2'd3
  } fmt_t;

  // lane 3 is alpha, lane 0 is blue (luminance for a8l8)
  typedef logic [3:0][7:0] lanes_t;
  typedef logic [3:0][8:0] pair_sum_t;

  // position of the item just presented at the input
  typedef struct packed {
    logic             odd_col;
    logic             odd_row;
    logic             row_end;
    logic [IDX_W-1:0] idx;
  } pos_t;

  function automatic lanes_t widen(input logic [PIXEL_W-1:0] px, input fmt_t fmt);
    lanes_t ch;
    logic [15:0] h;
    h = px[15:0];
    unique case (fmt)
      FMT_A8L8: begin
        ch[3] = h[15:8];
        ch[2] = 8'h00;
        ch[1] = 8'h00;
        ch[0] = h[7:0];
      end
      FMT_A1R5G5B5: begin
        ch[3] = {8{h[15]}};
        ch[2] = {h[14:10], 3'b000};
        ch[1] = {h[9:5], 3'b000};
        ch[0] = {h[4:0], 3'b000};
      end
      FMT_R5G6B5: begin
        ch[3] = 8'hff;
        ch[2] = {h[15:11], 3'b000};
        ch[1] = {h[10:5], 2'b00};
        ch[0] = {h[4:0], 3'b000};
      end
      default: begin
        ch[3] = px[31:24];
        ch[2] = px[23:16];
        ch[1] = px[15:8];
        ch[0] = px[7:0];
      end
    endcase
    return ch;
  endfunction

  function automatic logic [PIXEL_W-1:0] narrow(input lanes_t ch, input fmt_t fmt);
    logic [PIXEL_W-1:0] px;
    unique case (fmt)
      FMT_A8L8:     px = {16'h0000, ch[3], ch[0]};
      FMT_A1R5G5B5: px = {16'h0000, ch[3][7], ch[2][7:3], ch[1][7:3], ch[0][7:3]};
      FMT_R5G6B5:   px = {16'h0000, ch[2][7:3], ch[1][7:2], ch[0][7:3]};
      default:      px = {ch[3], ch[2], ch[1], ch[0]};
    endcase
    return px;
  endfunction

endpackage

FILE: design/mmd_front.sv
// ---------------------------------------------------------------------------
// mmd_front
// Raster position tracking: column counter, row parity and the held
// even-column pixel of the current pair.
// ---------------------------------------------------------------------------
module mmd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                start_of_frame,
  input  logic [mmd_pkg::PIXEL_W-1:0]         source_pixel,
  input  logic [mmd_pkg::WIDTH_W-1:0]         src_width,
  output mmd_pkg::pos_t                       pos,
  output logic [mmd_pkg::PIXEL_W-1:0]         left_hold
);

  logic [mmd_pkg::COL_W-1:0] column_count;
  logic                      odd_row;

  logic [mmd_pkg::CNT_W-1:0] w_eff;
  logic [mmd_pkg::CNT_W-1:0] base;
  logic [mmd_pkg::CNT_W-1:0] col;
  logic [mmd_pkg::CNT_W-1:0] col_inc;
  logic                      row;
  logic                      last;

  always_comb begin
    // widths above the line store size act as the maximum
    if (mmd_pkg::CNT_W'(src_width) > mmd_pkg::CNT_W'(mmd_pkg::MAX_WIDTH)) begin
      w_eff = mmd_pkg::CNT_W'(mmd_pkg::MAX_WIDTH);
    end else begin
      w_eff = mmd_pkg::CNT_W'(src_width);
    end
    base    = start_of_frame ? '0 : mmd_pkg::CNT_W'(column_count);
    row     = start_of_frame ? 1'b0 : odd_row;
    // a count left past a narrowed width restarts the row
    col     = (base >= w_eff) ? '0 : base;
    col_inc = col + mmd_pkg::CNT_W'(1);
    last    = col_inc >= w_eff;

    pos.odd_col = col[0];
    pos.odd_row = row;
    pos.idx     = col[mmd_pkg::IDX_W:1];
    pos.row_end = ((col >> 1) + mmd_pkg::CNT_W'(1)) == (w_eff >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      odd_row      <= 1'b0;
      left_hold    <= '0;
    end else if (accept) begin
      if (!col[0]) begin
        left_hold <= source_pixel;
      end
      if (last) begin
        column_count <= '0;
        odd_row      <= ~row;
      end else begin
        column_count <= col_inc[mmd_pkg::COL_W-1:0];
        odd_row      <= row;
      end
    end
  end

endmodule

FILE: design/mmd_line_store.sv
// ---------------------------------------------------------------------------
// mmd_line_store
// Line memory of the even-row pair sums, one write and one registered
// read port.
// ---------------------------------------------------------------------------
module mmd_line_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [mmd_pkg::IDX_W-1:0]    wr_addr,
  input  mmd_pkg::pair_sum_t           wr_data,
  input  logic                         rd_en,
  input  logic [mmd_pkg::IDX_W-1:0]    rd_addr,
  output mmd_pkg::pair_sum_t           rd_data
);

  mmd_pkg::pair_sum_t mem [mmd_pkg::LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/mmd_average.sv
// ---------------------------------------------------------------------------
// mmd_average
// Widens a pixel pair, forms the pair sums and the 2x2 box average
// with the stored upper-row sums, then narrows to the pixel format.
// ---------------------------------------------------------------------------
module mmd_average (
  input  logic [mmd_pkg::PIXEL_W-1:0] left_pixel,
  input  logic [mmd_pkg::PIXEL_W-1:0] right_pixel,
  input  mmd_pkg::pair_sum_t          upper_sum,
  input  mmd_pkg::fmt_t               fmt,
  output mmd_pkg::pair_sum_t          pair_sum,
  output logic [mmd_pkg::PIXEL_W-1:0] avg_pixel
);

  mmd_pkg::lanes_t l_ch;
  mmd_pkg::lanes_t r_ch;
  mmd_pkg::lanes_t o_ch;
  logic [9:0]      total [4];

  always_comb begin
    l_ch = mmd_pkg::widen(left_pixel, fmt);
    r_ch = mmd_pkg::widen(right_pixel, fmt);
    for (int k = 0; k < 4; k++) begin
      pair_sum[k] = {1'b0, l_ch[k]} + {1'b0, r_ch[k]};
      total[k]    = {1'b0, upper_sum[k]} + {1'b0, pair_sum[k]};
      // divide by four, truncating
      o_ch[k]     = total[k][9:2];
    end
    avg_pixel = mmd_pkg::narrow(o_ch, fmt);
  end

endmodule

FILE: design/mipmap_box_downsampler.sv
// ---------------------------------------------------------------------------
// mipmap_box_downsampler
// 2x2 box filter that turns one mip level, streamed in raster order,
// into the next smaller level.
// ---------------------------------------------------------------------------
// Accepts one source pixel every cycle for as long as results are taken;
// an accepted odd-row, odd-column pixel passes the input register stage, then the
// output register. Pixel pairs of even rows are summed per channel into a
// 2048-entry line memory; on the following odd row each completed pair is
// added to the stored sums, divided by four with truncation and emitted in
// the configured format, so a w-pixel row pair yields w/2 results. An odd
// trailing column or row produces nothing. start_of_frame restarts at the
// top-left pixel. pixel_format and src_width may only be written while the
// block is idle; no clearing pass is needed after reset.
module mipmap_box_downsampler (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mmd_pkg::PIXEL_W-1:0]         source_pixel,
  input  logic                                start_of_frame,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mmd_pkg::PIXEL_W-1:0]         out_pixel,
  output logic                                row_end,
  input  logic                                cfg_write,
  input  logic [mmd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mmd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  mmd_pkg::fmt_t                pixel_format;
  logic [mmd_pkg::WIDTH_W-1:0]  src_width;

  logic                         accept;
  mmd_pkg::pos_t                pos;
  logic [mmd_pkg::PIXEL_W-1:0]  left_hold;

  // input register stage
  logic                         s1_valid;
  logic [mmd_pkg::PIXEL_W-1:0]  s1_left;
  logic [mmd_pkg::PIXEL_W-1:0]  s1_right;
  mmd_pkg::pos_t                s1_pos;
  logic                         s1_result;
  logic                         s1_adv;

  logic                         mem_wr_en;
  logic                         mem_rd_en;
  mmd_pkg::pair_sum_t           upper_sum;
  mmd_pkg::pair_sum_t           pair_sum;
  logic [mmd_pkg::PIXEL_W-1:0]  avg_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= mmd_pkg::FMT_A8R8G8B8;
      src_width    <= mmd_pkg::WIDTH_RESET;
    end else if (cfg_write) begin
      if (cfg_index == mmd_pkg::CFG_PIXEL_FORMAT) begin
        pixel_format <= mmd_pkg::fmt_t'(cfg_data[1:0]);
      end else if (cfg_index == mmd_pkg::CFG_SRC_WIDTH) begin
        src_width <= cfg_data[mmd_pkg::WIDTH_W-1:0];
      end
    end
  end

  assign s1_result = s1_pos.odd_col & s1_pos.odd_row;
  // only items with a result can be held up by the output side
  assign s1_adv    = !s1_result || !out_valid || !out_stall;
  assign in_stall  = s1_valid && !s1_adv;
  assign accept    = in_valid && !in_stall;

  mmd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .start_of_frame (start_of_frame),
    .source_pixel   (source_pixel),
    .src_width      (src_width),
    .pos            (pos),
    .left_hold      (left_hold)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_left  <= left_hold;
      s1_right <= source_pixel;
      s1_pos   <= pos;
    end
  end

  // upper-row sums are fetched as the odd-column pixel comes in
  assign mem_rd_en = accept && pos.odd_col && pos.odd_row;
  assign mem_wr_en = s1_valid && s1_pos.odd_col && !s1_pos.odd_row;

  mmd_line_store u_line (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (s1_pos.idx),
    .wr_data (pair_sum),
    .rd_en   (mem_rd_en),
    .rd_addr (pos.idx),
    .rd_data (upper_sum)
  );

  mmd_average u_avg (
    .left_pixel  (s1_left),
    .right_pixel (s1_right),
    .upper_sum   (upper_sum),
    .fmt         (pixel_format),
    .pair_sum    (pair_sum),
    .avg_pixel   (avg_pixel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_result && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_result && (!out_valid || !out_stall)) begin
      out_pixel <= avg_pixel;
      row_end   <= s1_pos.row_end;
    end
  end

`ifndef SYNTHESIS
  // a line entry is never written and read back in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    !(mem_wr_en && mem_rd_en && (s1_pos.idx == pos.idx)))
    else $error("line store read and write collide");

  // the input only stalls behind a held item
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_result && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // a result item meeting a free output slot shows up next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_result && !(out_valid && out_stall)) |=> out_valid)
    else $error("result item lost between stages");
`endif

endmodule
